[sv/bffa_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap first-free allocator package
// Shared types, response codes and helpers for the allocator core.
// ----------------------------------------------------------------------------
package bffa_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_RANGE     = 2'd2,
    ST_SAME      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_WR_READ,
    S_WR_EVAL,
    S_RESP
  } state_t;

  typedef enum logic {
    REQ_FIND  = 1'b0,
    REQ_WRITE = 1'b1
  } req_type_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr_step;
    logic find_step;
    logic wr_read;
    logic wr_eval;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clr_last;
    logic find_done;
    logic range_err;
  } ctrl_sts_t;

  localparam logic [7:0] MSB_MASK  = 8'h80;
  localparam logic [7:0] FULL_BYTE = 8'hFF;

  // Number of ones above the first zero, counting from the most significant bit.
  function automatic logic [2:0] lead_ones(input logic [7:0] b);
    logic [2:0] n;
    logic       stop;
    n    = 3'd0;
    stop = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!stop) begin
        if (b[i]) begin
          n = n + 3'd1;
        end else begin
          stop = 1'b1;
        end
      end
    end
    return n;
  endfunction

endpackage

[sv/bffa_req_if.sv]
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one find or write request per transaction.
// ----------------------------------------------------------------------------
interface bffa_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [9:0] bit_index;
  logic       bit_value;

  modport source (output valid, output req_type, output bit_index, output bit_value,
                  input ready);
  modport sink   (input valid, input req_type, input bit_index, input bit_value,
                  output ready);
endinterface

[sv/bffa_rsp_if.sv]
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one result per request transaction.
// ----------------------------------------------------------------------------
interface bffa_rsp_if;
  logic                 valid;
  logic                 ready;
  bffa_pkg::status_t    status;
  logic [9:0]           found_index;
  logic [10:0]          free_count;

  modport source (output valid, output status, output found_index, output free_count,
                  input ready);
  modport sink   (input valid, input status, input found_index, input free_count,
                  output ready);
endinterface

[sv/bffa_ctrl.sv]
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences the clearing pass, the byte scan and the read-modify-write.
// ----------------------------------------------------------------------------
module bffa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_req_type,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bffa_pkg::ctrl_sts_t  sts,
  output bffa_pkg::ctrl_cmd_t  cmd
);
  import bffa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_req_type == REQ_WRITE) ? S_WR_READ : S_FIND;
        end
      end
      S_FIND: begin
        if (sts.find_done) state_nxt = S_RESP;
      end
      S_WR_READ: begin
        state_nxt = sts.range_err ? S_RESP : S_WR_EVAL;
      end
      S_WR_EVAL: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_CLEAR:   cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_FIND:    cmd.find_step = 1'b1;
      S_WR_READ: cmd.wr_read = 1'b1;
      S_WR_EVAL: cmd.wr_eval = 1'b1;
      S_RESP:    out_valid = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[sv/bffa_dp.sv]
// ----------------------------------------------------------------------------
// Allocator datapath
// Bitmap memory, scan pointers, free counter and result registers.
// ----------------------------------------------------------------------------
module bffa_dp #(
  parameter int MAP_BITS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bffa_pkg::ctrl_cmd_t  cmd,
  output bffa_pkg::ctrl_sts_t  sts,
  input  logic [9:0]           in_bit_index,
  input  logic                 in_bit_value,
  output bffa_pkg::status_t    res_status,
  output logic [9:0]           res_index,
  output logic [10:0]          res_free
);
  import bffa_pkg::*;

  localparam int MAP_BYTES = (MAP_BITS + 7) / 8;
  localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAP_BYTES + 1);
  localparam int FC_W      = $clog2(MAP_BITS + 1);
  localparam int WIDE_W    = (ADDR_W + 3 > 10) ? ADDR_W + 3 : 10;
  localparam int FCX_W     = (FC_W > 11) ? FC_W : 11;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);
  localparam logic [FC_W-1:0]   FC_FULL   = FC_W'(MAP_BITS);

  logic [7:0]        mem [0:MAP_BYTES-1];
  logic [7:0]        rd_data_r;

  logic [ADDR_W-1:0] clr_addr_r;
  logic [CNT_W-1:0]  scan_addr_r;
  logic [ADDR_W-1:0] chk_addr_r;
  logic              chk_vld_r;
  logic [FC_W-1:0]   free_r;
  logic [9:0]        idx_r;
  logic              val_r;
  status_t           res_status_r;
  logic [9:0]        res_index_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic              issue;
  logic              range_err;
  logic [WIDE_W-1:0] wide_idx;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        bit_mask;
  logic              cur_bit;
  logic              find_hit;
  logic              find_end;
  logic [ADDR_W+2:0] hit_idx;
  logic [WIDE_W-1:0] hit_wide;
  logic              hit_in_map;
  logic [FCX_W-1:0]  free_ext;

  assign issue      = scan_addr_r < CNT_W'(MAP_BYTES);
  assign range_err  = 32'(idx_r) >= 32'(MAP_BITS);
  assign wide_idx   = WIDE_W'(idx_r);
  assign wr_addr    = wide_idx[ADDR_W+2:3];
  assign bit_mask   = MSB_MASK >> idx_r[2:0];
  assign cur_bit    = |(rd_data_r & bit_mask);
  assign find_hit   = chk_vld_r && (rd_data_r != FULL_BYTE);
  assign find_end   = chk_vld_r && (rd_data_r == FULL_BYTE) && (chk_addr_r == LAST_ADDR);
  assign hit_idx    = {chk_addr_r, lead_ones(rd_data_r)};
  assign hit_wide   = WIDE_W'(hit_idx);
  assign hit_in_map = 32'(hit_idx) < 32'(MAP_BITS);
  assign free_ext   = FCX_W'(free_r);

  assign sts.clr_last  = clr_addr_r == LAST_ADDR;
  assign sts.find_done = find_hit || find_end;
  assign sts.range_err = range_err;

  assign res_status = res_status_r;
  assign res_index  = res_index_r;
  assign res_free   = free_ext[10:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = wr_addr;
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
    end else if (cmd.wr_eval && (cur_bit != val_r)) begin
      mem_we    = 1'b1;
      mem_wdata = val_r ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask);
    end
    if (cmd.find_step) begin
      mem_re    = issue;
      mem_raddr = scan_addr_r[ADDR_W-1:0];
    end else if (cmd.wr_read) begin
      mem_re    = !range_err;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      scan_addr_r <= '0;
      chk_vld_r   <= 1'b0;
      free_r      <= FC_FULL;
    end else begin
      if (cmd.clr_step && !sts.clr_last) clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (cmd.load) begin
        scan_addr_r <= '0;
        chk_vld_r   <= 1'b0;
      end else if (cmd.find_step) begin
        scan_addr_r <= scan_addr_r + CNT_W'(issue);
        chk_vld_r   <= issue;
      end
      if (cmd.wr_eval && (cur_bit != val_r)) begin
        if (val_r) begin
          if (free_r != '0) free_r <= free_r - FC_W'(1);
        end else begin
          if (free_r < FC_FULL) free_r <= free_r + FC_W'(1);
        end
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= in_bit_index;
      val_r <= in_bit_value;
    end
    if (cmd.find_step) begin
      chk_addr_r <= scan_addr_r[ADDR_W-1:0];
      if (find_hit && hit_in_map) begin
        res_status_r <= ST_OK;
        res_index_r  <= hit_wide[9:0];
      end else if (find_hit || find_end) begin
        // A zero in the slack bits of the last byte is not a free block.
        res_status_r <= ST_NONE_FREE;
        res_index_r  <= '0;
      end
    end
    if (cmd.wr_read && range_err) begin
      res_status_r <= ST_RANGE;
      res_index_r  <= idx_r;
    end
    if (cmd.wr_eval) begin
      res_status_r <= (cur_bit == val_r) ? ST_SAME : ST_OK;
      res_index_r  <= idx_r;
    end
  end

endmodule

[sv/bitmap_first_free_allocator_core.sv]
// ----------------------------------------------------------------------------
// Bitmap first-free allocator core
// Allocation bitmap with first-free search and single-bit set/clear.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one request per transaction: a find (req_type 0) or a
//   write of bit_value to bit_index (req_type 1). out_rsp returns exactly one
//   result per request: status, found or echoed index, and the free count
//   after the request.
//   The core handles one request at a time; in_req.ready is high only when
//   no request is outstanding.
//   A write reads the addressed bitmap byte through the registered read of
//   the bitmap memory, then writes the byte back if the bit changes; an
//   out-of-range index is answered without the read. A find scans one
//   bitmap byte per cycle through the single memory read port, stopping at
//   the first byte with a zero or after the last byte.
//   The next request is accepted in the cycle after the result is taken.
//   After reset the bitmap memory is cleared one byte per cycle, during
//   which in_req.ready stays low; the free count resets to MAP_BITS.
//   When the receiver stalls, the result is held stable on out_rsp and no
//   new request is accepted until it has been taken.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_core #(
  parameter int MAP_BITS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  bffa_req_if.sink    in_req,
  bffa_rsp_if.source  out_rsp
);
  import bffa_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  bffa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_req_type (in_req.req_type),
    .in_ready    (in_req.ready),
    .out_valid   (out_rsp.valid),
    .out_ready   (out_rsp.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  bffa_dp #(
    .MAP_BITS (MAP_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_bit_index (in_req.bit_index),
    .in_bit_value (in_req.bit_value),
    .res_status   (out_rsp.status),
    .res_index    (out_rsp.found_index),
    .res_free     (out_rsp.free_count)
  );

  // One request in flight: never ready while a result is on offer.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> !out_rsp.valid)
    else $error("request channel ready while a result is pending");

  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("second request accepted before the first was answered");

  a_none_free_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status == ST_NONE_FREE) |-> out_rsp.found_index == 10'd0)
    else $error("none-free result with non-zero index");

  a_free_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && $past(out_rsp.valid)) |-> $stable(out_rsp.free_count))
    else $error("free count changed while a result was held");

endmodule
